@@ hw/rtl/utf8d_pkg.sv @@
package utf8d_pkg;

	localparam int unsigned CpW = 21;

	localparam logic [CpW-1:0] ReplChar  = 21'h00fffd;
	localparam logic [CpW-1:0] MaxScalar = 21'h10ffff;
	localparam logic [CpW-1:0] SurrLo    = 21'h00d800;
	localparam logic [CpW-1:0] SurrHi    = 21'h00dfff;
	localparam logic [CpW-1:0] Min2      = 21'h000080;
	localparam logic [CpW-1:0] Min3      = 21'h000800;
	localparam logic [CpW-1:0] Min4      = 21'h010000;

	localparam logic [7:0] Lead2Lo = 8'hc2;
	localparam logic [7:0] Lead2Hi = 8'hdf;
	localparam logic [7:0] Lead3Lo = 8'he0;
	localparam logic [7:0] Lead3Hi = 8'hef;
	localparam logic [7:0] Lead4Lo = 8'hf0;
	localparam logic [7:0] Lead4Hi = 8'hf4;

	localparam logic [2:0] Len2 = 3'd2;
	localparam logic [2:0] Len3 = 3'd3;
	localparam logic [2:0] Len4 = 3'd4;

	// One input byte of text
	typedef struct packed {
		logic [7:0] byte_in;
		logic       final_byte;
	} text_item_t;

	// One decoded code point
	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           replaced;
		logic           last_of_run;
		logic           text_end;
	} code_item_t;

	// Open-sequence state
	typedef struct packed {
		logic [2:0]     expected_length;
		logic [1:0]     bytes_taken;
		logic [CpW-1:0] partial_value;
	} dec_state_t;

	// Results of one byte: count-1 replacement chars, then the tail result
	typedef struct packed {
		logic [2:0]     count;
		logic [CpW-1:0] tail_cp;
		logic           tail_repl;
		logic           text_end;
	} burst_t;

	// Overlong, surrogate and range check of a completed sequence
	function automatic logic cp_acceptable(input logic [CpW-1:0] v, input logic [2:0] len);
		logic ok;
		ok = 1'b1;
		if (len == Len2 && v < Min2) ok = 1'b0;
		if (len == Len3 && v < Min3) ok = 1'b0;
		if (len == Len4 && v < Min4) ok = 1'b0;
		if (v > MaxScalar) ok = 1'b0;
		if (v >= SurrLo && v <= SurrHi) ok = 1'b0;
		return ok;
	endfunction

endpackage

@@ hw/rtl/utf8_validating_decoder.sv @@
// UTF-8 validating decoder.
// Input channel (text_valid / text_stall / text_item): one byte of text per
// transfer, with final_byte set on the last byte of the text.
// Output channel (code_valid / code_stall / code_item): decoded code points,
// with U+FFFD and replaced set for each invalid byte. last_of_run marks the
// last result caused by one byte; text_end marks results of the final byte.
// Path: a byte's first result passes through the input register, then is
// decoded into the output register, from which it transfers out.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver does not stall. A byte that gives several results (up
// to four) holds the output register until all have left; a following byte
// that has results waits, one that only opens or extends a sequence goes through.
// Reset clears the open-sequence state and empties both registers.
// When the receiver stalls, the current result holds; bytes that only open or
// extend a sequence are still taken, and a byte with results waits in the input register with text_stall raised.
module utf8_validating_decoder
	import utf8d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  text_item_t text_item,
	output logic       code_valid,
	input  logic       code_stall,
	output code_item_t code_item
);

	logic       valid_s1;
	text_item_t item_s1;
	dec_state_t state_q;
	dec_state_t state_nxt;
	burst_t     burst;
	logic       load_ok;
	logic       consume;
	logic       load;

	// Input register
	assign consume    = valid_s1 && ((burst.count == 3'd0) || load_ok);
	assign load       = valid_s1 && (burst.count != 3'd0) && load_ok;
	assign text_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			item_s1 <= text_item;
		end
	end

	// Sequence state advances as each byte is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	utf8d_decode u_decode (
		.state     (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.burst     (burst)
	);

	utf8d_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.burst      (burst),
		.load_ok    (load_ok),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_item  (code_item)
	);

endmodule

@@ hw/rtl/utf8d_decode.sv @@
module utf8d_decode
	import utf8d_pkg::*;
(
	input  dec_state_t state,
	input  text_item_t item,
	output dec_state_t state_nxt,
	output burst_t     burst
);

	logic [7:0]     b;
	logic           fin;
	logic           is_cont;
	// lead decode
	logic           lead_res;
	logic [CpW-1:0] lead_cp;
	logic           lead_repl;
	logic           lead_open;
	logic [2:0]     lead_len;
	logic [CpW-1:0] lead_pv;
	// continuation
	logic [2:0]     taken_inc;
	logic [CpW-1:0] pv_inc;

	assign b       = item.byte_in;
	assign fin     = item.final_byte;
	assign is_cont = (b[7:6] == 2'b10);

	// Classify the byte as a lead
	always_comb begin
		lead_res  = 1'b1;
		lead_cp   = ReplChar;
		lead_repl = 1'b1;
		lead_open = 1'b0;
		lead_len  = 3'd0;
		lead_pv   = '0;
		if (b[7] == 1'b0) begin
			lead_cp   = {13'd0, b};
			lead_repl = 1'b0;
		end else if (b inside {[Lead2Lo:Lead2Hi]}) begin
			lead_len = Len2;
			lead_pv  = {16'd0, b[4:0]};
		end else if (b inside {[Lead3Lo:Lead3Hi]}) begin
			lead_len = Len3;
			lead_pv  = {17'd0, b[3:0]};
		end else if (b inside {[Lead4Lo:Lead4Hi]}) begin
			lead_len = Len4;
			lead_pv  = {18'd0, b[2:0]};
		end
		// a valid lead opens a sequence, or is truncated at once by text end
		if (lead_len != 3'd0) begin
			lead_open = !fin;
			lead_res  = fin;
		end
	end

	assign taken_inc = {1'b0, state.bytes_taken} + 3'd1;
	assign pv_inc    = {state.partial_value[CpW-7:0], b[5:0]};

	// Next state and result burst
	always_comb begin
		state_nxt         = '0;
		burst.count       = 3'd0;
		burst.tail_cp     = ReplChar;
		burst.tail_repl   = 1'b1;
		burst.text_end    = fin;
		if (state.expected_length == 3'd0 || !is_cont) begin
			// idle, or a broken sequence followed by a byte that is not a continuation
			if (state.expected_length != 3'd0) begin
				burst.count = {1'b0, state.bytes_taken};
			end
			if (lead_res) begin
				burst.count     = burst.count + 3'd1;
				burst.tail_cp   = lead_cp;
				burst.tail_repl = lead_repl;
			end
			if (lead_open) begin
				state_nxt.expected_length = lead_len;
				state_nxt.bytes_taken     = 2'd1;
				state_nxt.partial_value   = lead_pv;
			end
		end else if (taken_inc >= state.expected_length) begin
			if (cp_acceptable(pv_inc, state.expected_length)) begin
				burst.count     = 3'd1;
				burst.tail_cp   = pv_inc;
				burst.tail_repl = 1'b0;
			end else begin
				burst.count = state.expected_length;
			end
		end else if (fin) begin
			burst.count = taken_inc;
		end else begin
			state_nxt.expected_length = state.expected_length;
			state_nxt.bytes_taken     = taken_inc[1:0];
			state_nxt.partial_value   = pv_inc;
		end
	end

endmodule

@@ hw/rtl/utf8d_emit.sv @@
module utf8d_emit
	import utf8d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  burst_t     burst,
	output logic       load_ok,
	output logic       code_valid,
	input  logic       code_stall,
	output code_item_t code_item
);

	logic [2:0]     rem_q;
	logic [CpW-1:0] cp_q;
	logic           repl_q;
	logic           fin_q;
	logic           xfer;
	logic           on_tail;

	assign on_tail    = (rem_q == 3'd1);
	assign code_valid = (rem_q != 3'd0);
	assign xfer       = code_valid && !code_stall;
	// a new burst may enter when none is held or the held one leaves with this transfer
	assign load_ok    = (rem_q == 3'd0) || (on_tail && !code_stall);

	// Remaining results of the held burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (load) begin
			rem_q <= burst.count;
		end else if (xfer) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= burst.tail_cp;
			repl_q <= burst.tail_repl;
			fin_q  <= burst.text_end;
		end
	end

	// Leading results are replacement chars, the tail carries the decoded value
	always_comb begin
		code_item.code_point  = on_tail ? cp_q : ReplChar;
		code_item.replaced    = on_tail ? repl_q : 1'b1;
		code_item.last_of_run = on_tail;
		code_item.text_end    = fin_q;
	end

endmodule
